// ===== sv/ftm_pkg.sv =====
package ftm_pkg;

  localparam int CODE_W  = 8;
  localparam int SEV_W   = 2;
  localparam int TIME_W  = 16;
  localparam int SPEED_W = 16;
  localparam int THR_W   = 15;
  localparam int RIDX_W  = 4;
  localparam int ACT_W   = 2;
  localparam int CFG_AW  = 2;
  localparam int CFG_DW  = 16;

  localparam logic [ACT_W-1:0] ACT_TICK   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REPORT = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ACK    = 2'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd3;

  localparam logic [SEV_W-1:0] SEV_WARNING  = 2'd0;
  localparam logic [SEV_W-1:0] SEV_SELF_CLR = 2'd1;
  localparam logic [SEV_W-1:0] SEV_LATCHED  = 2'd2;
  localparam logic [SEV_W-1:0] SEV_OVER     = 2'd3;

  localparam logic [CFG_AW-1:0] REG_SPEED_THR  = 2'd0;
  localparam logic [CFG_AW-1:0] REG_GATE_CODE  = 2'd1;
  localparam logic [CFG_AW-1:0] REG_NREADY_CODE = 2'd2;
  localparam logic [CFG_AW-1:0] REG_NREADY_TMO = 2'd3;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [SEV_W-1:0]  sev;
    logic [TIME_W-1:0] timer;
  } entry_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SCAN,
    OP_FILTER,
    OP_READ,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    SRC_ITEM,
    SRC_GATE,
    SRC_NREADY
  } src_t;

  typedef struct packed {
    op_t  op;
    src_t src;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic need_gate;
    logic need_nready;
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GATE,
    ST_NREADY,
    ST_REPORT,
    ST_FILTER,
    ST_READ,
    ST_EMIT
  } state_t;

endpackage

// ===== sv/fault_table_manager.sv =====
// Inverter fault table. An item is accepted on a clock edge where start is high
// and busy is low; its single result transaction appears in the cycle after the
// last internal step, on the result ports for exactly one cycle, marked by done,
// and the receiver cannot stall it. The table is a memory of MAX_FAULTS entries
// with one read and one write port, walked one entry per cycle. A read does not
// walk the table; a report or an acknowledge walks it once, and a tick walks it
// once per gate fault or not-ready report that a line edge calls for and once
// for the countdown pass, and each report may grow it by one entry. Removal
// compacts the table in the same pass, so entry order is kept. The gate enable
// stays low after reset until the first tick, then at each tick follows the
// absence of any non-warning fault. The user must write configuration through
// cfg_we, cfg_addr and cfg_wdata only while idle; the block does not enforce it.
module fault_table_manager import ftm_pkg::*; #(
  parameter int MAX_FAULTS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  output logic                      busy,
  input  logic [ACT_W-1:0]          action,
  input  logic [TIME_W-1:0]         elapsed_ms,
  input  logic                      gate_fault_line,
  input  logic                      gate_ready_line,
  input  logic signed [SPEED_W-1:0] speed,
  input  logic [CODE_W-1:0]         fault_code,
  input  logic [SEV_W-1:0]          severity,
  input  logic [TIME_W-1:0]         timeout_ms,
  input  logic [RIDX_W-1:0]         read_index,
  input  logic                      cfg_we,
  input  logic [CFG_AW-1:0]         cfg_addr,
  input  logic [CFG_DW-1:0]         cfg_wdata,
  output logic                      done,
  output logic                      gate_enable,
  output logic                      system_faulted,
  output logic [$clog2(MAX_FAULTS+1)-1:0] fault_count,
  output logic                      report_dropped,
  output logic                      entry_valid,
  output logic [CODE_W-1:0]         entry_code,
  output logic [SEV_W-1:0]          entry_severity,
  output logic [TIME_W-1:0]         entry_time_left
);

  // The controller sequences the walks; the datapath owns the table and flags.
  cmd_t    cmd;
  status_t status;

  ftm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .action (action),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  ftm_dp #(
    .MAX_FAULTS (MAX_FAULTS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .action          (action),
    .elapsed_ms      (elapsed_ms),
    .gate_fault_line (gate_fault_line),
    .gate_ready_line (gate_ready_line),
    .speed           (speed),
    .fault_code      (fault_code),
    .severity        (severity),
    .timeout_ms      (timeout_ms),
    .read_index      (read_index),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .done            (done),
    .gate_enable     (gate_enable),
    .system_faulted  (system_faulted),
    .fault_count     (fault_count),
    .report_dropped  (report_dropped),
    .entry_valid     (entry_valid),
    .entry_code      (entry_code),
    .entry_severity  (entry_severity),
    .entry_time_left (entry_time_left)
  );

endmodule

// ===== sv/ftm_ctrl.sv =====
module ftm_ctrl import ftm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACT_W-1:0] action,
  input  status_t          status,
  output cmd_t             cmd,
  output logic             busy
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    cmd.src    = SRC_ITEM;
    busy       = 1'b1;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.op = OP_LOAD;
          case (action)
            ACT_TICK:   state_next = ST_GATE;
            ACT_REPORT: state_next = ST_REPORT;
            ACT_ACK:    state_next = ST_FILTER;
            default:    state_next = ST_READ;
          endcase
        end
      end
      ST_GATE: begin
        if (status.need_gate) begin
          cmd.op  = OP_SCAN;
          cmd.src = SRC_GATE;
          if (status.walk_done) begin
            state_next = ST_NREADY;
          end
        end else begin
          state_next = ST_NREADY;
        end
      end
      ST_NREADY: begin
        if (status.need_nready) begin
          cmd.op  = OP_SCAN;
          cmd.src = SRC_NREADY;
          if (status.walk_done) begin
            state_next = ST_FILTER;
          end
        end else begin
          state_next = ST_FILTER;
        end
      end
      ST_REPORT: begin
        cmd.op = OP_SCAN;
        if (status.walk_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_FILTER: begin
        cmd.op = OP_FILTER;
        if (status.walk_done) begin
          state_next = ST_EMIT;
        end
      end
      ST_READ: begin
        cmd.op     = OP_READ;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.op     = OP_EMIT;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== sv/ftm_dp.sv =====
module ftm_dp import ftm_pkg::*; #(
  parameter int MAX_FAULTS = 16,
  parameter int IW = (MAX_FAULTS > 1) ? $clog2(MAX_FAULTS) : 1,
  parameter int CW = $clog2(MAX_FAULTS + 1)
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output status_t            status,
  input  logic [ACT_W-1:0]   action,
  input  logic [TIME_W-1:0]  elapsed_ms,
  input  logic               gate_fault_line,
  input  logic               gate_ready_line,
  input  logic signed [SPEED_W-1:0] speed,
  input  logic [CODE_W-1:0]  fault_code,
  input  logic [SEV_W-1:0]   severity,
  input  logic [TIME_W-1:0]  timeout_ms,
  input  logic [RIDX_W-1:0]  read_index,
  input  logic               cfg_we,
  input  logic [CFG_AW-1:0]  cfg_addr,
  input  logic [CFG_DW-1:0]  cfg_wdata,
  output logic               done,
  output logic               gate_enable,
  output logic               system_faulted,
  output logic [CW-1:0]      fault_count,
  output logic               report_dropped,
  output logic               entry_valid,
  output logic [CODE_W-1:0]  entry_code,
  output logic [SEV_W-1:0]   entry_severity,
  output logic [TIME_W-1:0]  entry_time_left
);

  localparam int XW = (CW > RIDX_W) ? CW + 1 : RIDX_W + 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_FAULTS);

  entry_t mem [MAX_FAULTS];
  entry_t rdata;

  logic [THR_W-1:0]  speed_thr;
  logic [CODE_W-1:0] gate_code;
  logic [CODE_W-1:0] nready_code;
  logic [TIME_W-1:0] nready_tmo;

  logic [ACT_W-1:0]   a_act;
  logic [TIME_W-1:0]  a_elapsed;
  logic [SPEED_W-1:0] a_speed;
  logic [CODE_W-1:0]  a_code;
  logic [SEV_W-1:0]   a_sev;
  logic [TIME_W-1:0]  a_tmo;
  logic [RIDX_W-1:0]  a_ridx;

  logic [CW-1:0] count;
  logic [CW-1:0] rd_ptr;
  logic [CW-1:0] wr_ptr;
  logic          pend;
  logic          faulted;
  logic          acc_faulted;
  logic          gate_seen;
  logic          nready_seen;
  logic          need_gate;
  logic          need_nready;
  logic          dropped;
  logic          rd_valid;

  logic              ren;
  logic [IW-1:0]     raddr;
  logic              wen;
  logic [IW-1:0]     waddr;
  entry_t            wdata;
  logic              walk_done;
  logic              hit;
  logic              keep;
  logic              miss;

  logic [CODE_W-1:0] s_code;
  logic [SEV_W-1:0]  s_sev;
  logic [TIME_W-1:0] s_tmo;
  logic [TIME_W-1:0] abs_speed;
  logic              slow;
  logic [TIME_W-1:0] dec_timer;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_thr   <= THR_W'(26);
      gate_code   <= CODE_W'(254);
      nready_code <= CODE_W'(255);
      nready_tmo  <= TIME_W'(1000);
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SPEED_THR:   speed_thr   <= cfg_wdata[THR_W-1:0];
        REG_GATE_CODE:   gate_code   <= cfg_wdata[CODE_W-1:0];
        REG_NREADY_CODE: nready_code <= cfg_wdata[CODE_W-1:0];
        REG_NREADY_TMO:  nready_tmo  <= cfg_wdata[TIME_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (ren) begin
      rdata <= mem[raddr];
    end
  end

  always_comb begin
    case (cmd.src)
      SRC_GATE: begin
        s_code = gate_code;
        s_sev  = SEV_LATCHED;
        s_tmo  = '0;
      end
      SRC_NREADY: begin
        s_code = nready_code;
        s_sev  = SEV_SELF_CLR;
        s_tmo  = nready_tmo;
      end
      default: begin
        s_code = a_code;
        s_sev  = (a_sev == SEV_OVER) ? SEV_LATCHED : a_sev;
        s_tmo  = a_tmo;
      end
    endcase
  end

  // Two's complement magnitude; the most negative speed maps to 0x8000.
  assign abs_speed = a_speed[SPEED_W-1] ? (~a_speed + TIME_W'(1)) : a_speed;
  assign slow      = abs_speed < {1'b0, speed_thr};
  assign dec_timer = (rdata.timer > a_elapsed) ? (rdata.timer - a_elapsed) : '0;

  always_comb begin
    ren       = 1'b0;
    raddr     = IW'(rd_ptr);
    wen       = 1'b0;
    waddr     = IW'(wr_ptr);
    wdata     = rdata;
    walk_done = 1'b0;
    hit       = 1'b0;
    keep      = 1'b0;
    miss      = 1'b0;
    case (cmd.op)
      OP_SCAN: begin
        hit = pend && (rdata.code == s_code);
        if (hit) begin
          walk_done = 1'b1;
          if (s_sev == SEV_SELF_CLR) begin
            wen         = 1'b1;
            waddr       = IW'(rd_ptr - CW'(1));
            wdata.timer = s_tmo;
          end
        end else if (rd_ptr < count) begin
          ren = 1'b1;
        end else if (!pend) begin
          walk_done = 1'b1;
          miss      = 1'b1;
          if (count < MAX_CNT) begin
            wen   = 1'b1;
            waddr = IW'(count);
            wdata = '{code: s_code, sev: s_sev, timer: s_tmo};
          end
        end
      end
      OP_FILTER: begin
        if (pend) begin
          if (a_act == ACT_TICK) begin
            if (rdata.sev == SEV_SELF_CLR) begin
              wdata.timer = dec_timer;
              keep        = !((dec_timer == '0) && slow);
            end else begin
              keep = 1'b1;
            end
          end else begin
            keep = (rdata.sev != SEV_LATCHED);
          end
          wen = keep;
        end
        if (rd_ptr < count) begin
          ren = 1'b1;
        end
        walk_done = !pend && (rd_ptr == count);
      end
      OP_READ: begin
        ren   = 1'b1;
        raddr = IW'(a_ridx);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_LOAD) begin
      a_act     <= action;
      a_elapsed <= elapsed_ms;
      a_speed   <= speed;
      a_code    <= fault_code;
      a_sev     <= severity;
      a_tmo     <= timeout_ms;
      a_ridx    <= read_index;
    end
    if (cmd.op == OP_READ) begin
      rd_valid <= (XW'(a_ridx) < XW'(count)) && (XW'(a_ridx) < XW'(MAX_FAULTS));
    end
    if (cmd.op == OP_EMIT) begin
      entry_valid     <= (a_act == ACT_READ) && rd_valid;
      entry_code      <= ((a_act == ACT_READ) && rd_valid) ? rdata.code : '0;
      entry_severity  <= ((a_act == ACT_READ) && rd_valid) ? rdata.sev : '0;
      entry_time_left <= ((a_act == ACT_READ) && rd_valid) ? rdata.timer : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      rd_ptr      <= '0;
      wr_ptr      <= '0;
      pend        <= 1'b0;
      faulted     <= 1'b0;
      acc_faulted <= 1'b0;
      gate_seen   <= 1'b0;
      nready_seen <= 1'b0;
      need_gate   <= 1'b0;
      need_nready <= 1'b0;
      dropped     <= 1'b0;
      gate_enable <= 1'b0;
      done        <= 1'b0;
    end else begin
      done <= (cmd.op == OP_EMIT);
      if (ren && (cmd.op != OP_READ)) begin
        rd_ptr <= rd_ptr + CW'(1);
      end
      // No read is issued on the last cycle of a walk, so this also clears pend.
      if (cmd.op == OP_SCAN || cmd.op == OP_FILTER) begin
        pend <= ren;
      end
      case (cmd.op)
        OP_LOAD: begin
          rd_ptr      <= '0;
          wr_ptr      <= '0;
          pend        <= 1'b0;
          acc_faulted <= 1'b0;
          dropped     <= 1'b0;
          if (action == ACT_TICK) begin
            need_gate   <= gate_fault_line && !gate_seen;
            need_nready <= !gate_ready_line && !nready_seen;
            gate_seen   <= gate_fault_line;
            nready_seen <= !gate_ready_line;
          end
        end
        OP_SCAN: begin
          if (miss) begin
            if (count < MAX_CNT) begin
              count <= count + CW'(1);
              if (s_sev != SEV_WARNING) begin
                faulted <= 1'b1;
              end
            end else begin
              dropped <= 1'b1;
            end
          end
          if (walk_done) begin
            rd_ptr <= '0;
          end
        end
        OP_FILTER: begin
          if (keep) begin
            wr_ptr <= wr_ptr + CW'(1);
            if (rdata.sev != SEV_WARNING) begin
              acc_faulted <= 1'b1;
            end
          end
          if (walk_done) begin
            count   <= wr_ptr;
            faulted <= acc_faulted;
            if (a_act == ACT_TICK) begin
              gate_enable <= !acc_faulted;
            end
            rd_ptr      <= '0;
            wr_ptr      <= '0;
            acc_faulted <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign status.walk_done   = walk_done;
  assign status.need_gate   = need_gate;
  assign status.need_nready = need_nready;

  assign system_faulted = faulted;
  assign fault_count    = count;
  assign report_dropped = dropped;

endmodule

// ===== tb/sv/fault_table_manager_tb.sv =====
module fault_table_manager_tb;
  import ftm_pkg::*;

  localparam int NUM_SLOTS  = 16;
  localparam int CNT_W      = $clog2(NUM_SLOTS + 1);
  localparam int RAND_ITEMS = 1950;
  localparam int CYCLE_CAP  = 1500000;
  // Settle time after the last result, covering a tick over a full table.
  localparam int SETTLE_CYC = 3 * (NUM_SLOTS + 3) + 10;

  logic                      clk;
  logic                      rst;
  logic                      start;
  logic                      busy;
  logic [ACT_W-1:0]          action;
  logic [TIME_W-1:0]         elapsed_ms;
  logic                      gate_fault_line;
  logic                      gate_ready_line;
  logic signed [SPEED_W-1:0] speed;
  logic [CODE_W-1:0]         fault_code;
  logic [SEV_W-1:0]          severity;
  logic [TIME_W-1:0]         timeout_ms;
  logic [RIDX_W-1:0]         read_index;
  logic                      cfg_we;
  logic [CFG_AW-1:0]         cfg_addr;
  logic [CFG_DW-1:0]         cfg_wdata;
  logic                      done;
  logic                      gate_enable;
  logic                      system_faulted;
  logic [CNT_W-1:0]          fault_count;
  logic                      report_dropped;
  logic                      entry_valid;
  logic [CODE_W-1:0]         entry_code;
  logic [SEV_W-1:0]          entry_severity;
  logic [TIME_W-1:0]         entry_time_left;

  fault_table_manager #(.MAX_FAULTS(NUM_SLOTS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .action(action),
    .elapsed_ms(elapsed_ms), .gate_fault_line(gate_fault_line),
    .gate_ready_line(gate_ready_line), .speed(speed), .fault_code(fault_code),
    .severity(severity), .timeout_ms(timeout_ms), .read_index(read_index),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata), .done(done),
    .gate_enable(gate_enable), .system_faulted(system_faulted),
    .fault_count(fault_count), .report_dropped(report_dropped),
    .entry_valid(entry_valid), .entry_code(entry_code),
    .entry_severity(entry_severity), .entry_time_left(entry_time_left)
  );

  // One command as the block sees it on its input ports.
  typedef struct {
    logic [ACT_W-1:0]          act;
    logic [TIME_W-1:0]         elapsed;
    logic                      fline;
    logic                      rline;
    logic signed [SPEED_W-1:0] spd;
    logic [CODE_W-1:0]         code;
    logic [SEV_W-1:0]          sev;
    logic [TIME_W-1:0]         tmo;
    logic [RIDX_W-1:0]         ridx;
  } command_t;

  // One status transaction as it comes back on the result ports.
  typedef struct {
    logic              gate_en;
    logic              faulted;
    logic [CNT_W-1:0]  count;
    logic              dropped;
    logic              valid;
    logic [CODE_W-1:0] code;
    logic [SEV_W-1:0]  sev;
    logic [TIME_W-1:0] time_left;
  } result_t;

  // A directed row. When has_typed is set, the status is typed in by hand and
  // must also agree with what the table shadow computes.
  typedef struct {
    command_t cmd;
    bit       has_typed;
    result_t  typed;
  } directed_row_t;

  // Shadow copy of the fault table and its configuration registers.
  logic [THR_W-1:0]  thr_reg;
  logic [CODE_W-1:0] gate_code_reg;
  logic [CODE_W-1:0] nready_code_reg;
  logic [TIME_W-1:0] nready_tmo_reg;
  logic [CODE_W-1:0] tbl_code  [NUM_SLOTS];
  logic [SEV_W-1:0]  tbl_sev   [NUM_SLOTS];
  logic [TIME_W-1:0] tbl_timer [NUM_SLOTS];
  int                tbl_count;
  logic              tbl_faulted;
  logic              gate_seen;
  logic              nready_seen;
  logic              gate_en_shadow;

  result_t pending_status[$];
  int      mismatches;
  int      statuses_seen;
  int      cycle_count;
  int      send_idle_pct;
  int      ticks_sent, reports_sent, acks_sent, reads_sent, drops_seen;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // The run ends here if the block stops answering.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("Timeout after %0d cycles, %0d transactions outstanding", cycle_count,
               pending_status.size());
      $display("FAIL");
      $finish;
    end
  end

  function automatic void shadow_reset();
    thr_reg         = 15'd26;
    gate_code_reg   = 8'd254;
    nready_code_reg = 8'd255;
    nready_tmo_reg  = 16'd1000;
    tbl_count       = 0;
    tbl_faulted     = 1'b0;
    gate_seen       = 1'b0;
    nready_seen     = 1'b0;
    gate_en_shadow  = 1'b0;
  endfunction

  function automatic void refresh_faulted();
    tbl_faulted = 1'b0;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_sev[i] != SEV_WARNING) begin
        tbl_faulted = 1'b1;
      end
    end
  endfunction

  // Delete one entry and close the gap so that the arrival order is kept.
  function automatic void drop_slot(int pos);
    for (int i = pos; i + 1 < tbl_count; i++) begin
      tbl_code[i]  = tbl_code[i + 1];
      tbl_sev[i]   = tbl_sev[i + 1];
      tbl_timer[i] = tbl_timer[i + 1];
    end
    tbl_count--;
    refresh_faulted();
  endfunction

  // Add or refresh one fault. Returns 1 when the table was full.
  function automatic bit log_fault(logic [CODE_W-1:0] code, logic [SEV_W-1:0] sev,
                                   logic [TIME_W-1:0] tmo);
    logic [SEV_W-1:0] stored_sev;
    stored_sev = (sev == SEV_OVER) ? SEV_LATCHED : sev;
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_code[i] == code) begin
        // A repeat keeps the stored severity; only a self-clearing repeat re-arms.
        if (stored_sev == SEV_SELF_CLR) begin
          tbl_timer[i] = tmo;
        end
        return 1'b0;
      end
    end
    if (tbl_count >= NUM_SLOTS) begin
      return 1'b1;
    end
    tbl_code[tbl_count]  = code;
    tbl_sev[tbl_count]   = stored_sev;
    tbl_timer[tbl_count] = tmo;
    tbl_count++;
    if (stored_sev != SEV_WARNING) begin
      tbl_faulted = 1'b1;
    end
    return 1'b0;
  endfunction

  // Apply one command to the shadow table and return the status it should produce.
  function automatic result_t predict_status(command_t c);
    result_t s;
    logic [16:0] abs_speed;
    logic [TIME_W-1:0] remaining;
    s = '{default: '0};
    case (c.act)
      ACT_TICK: begin
        abs_speed = c.spd[15] ? (17'h10000 - {1'b0, c.spd}) : {1'b0, c.spd};
        // Rising edge of the gate fault line becomes a latched fault.
        if (c.fline && !gate_seen) begin
          if (log_fault(gate_code_reg, SEV_LATCHED, '0)) begin
            s.dropped = 1'b1;
          end
          gate_seen = 1'b1;
        end else if (!c.fline) begin
          gate_seen = 1'b0;
        end
        // Falling edge of the ready line becomes a self-clearing fault.
        if (!c.rline && !nready_seen) begin
          if (log_fault(nready_code_reg, SEV_SELF_CLR, nready_tmo_reg)) begin
            s.dropped = 1'b1;
          end
          nready_seen = 1'b1;
        end else if (c.rline) begin
          nready_seen = 1'b0;
        end
        for (int k = tbl_count; k > 0; k--) begin
          if (tbl_sev[k - 1] == SEV_SELF_CLR) begin
            remaining = (tbl_timer[k - 1] > c.elapsed) ? tbl_timer[k - 1] - c.elapsed : '0;
            tbl_timer[k - 1] = remaining;
            if (remaining == '0 && abs_speed < {2'b00, thr_reg}) begin
              drop_slot(k - 1);
            end
          end
        end
        gate_en_shadow = !tbl_faulted;
      end
      ACT_REPORT: begin
        s.dropped = log_fault(c.code, c.sev, c.tmo);
      end
      ACT_ACK: begin
        for (int k = tbl_count; k > 0; k--) begin
          if (tbl_sev[k - 1] == SEV_LATCHED) begin
            drop_slot(k - 1);
          end
        end
      end
      default: begin
        if (int'(c.ridx) < tbl_count) begin
          s.valid     = 1'b1;
          s.code      = tbl_code[c.ridx];
          s.sev       = tbl_sev[c.ridx];
          s.time_left = tbl_timer[c.ridx];
        end
      end
    endcase
    s.gate_en = gate_en_shadow;
    s.faulted = tbl_faulted;
    s.count   = CNT_W'(tbl_count);
    return s;
  endfunction

  function automatic bit same_status(result_t a, result_t b);
    return a.gate_en == b.gate_en && a.faulted == b.faulted && a.count == b.count &&
           a.dropped == b.dropped && a.valid == b.valid && a.code == b.code &&
           a.sev == b.sev && a.time_left == b.time_left;
  endfunction

  function automatic void note_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch (%s) at cycle %0d", what, cycle_count);
      $display("  expected en=%0b flt=%0b cnt=%0d drop=%0b vld=%0b code=%0d sev=%0d t=%0d",
               want.gate_en, want.faulted, want.count, want.dropped, want.valid,
               want.code, want.sev, want.time_left);
      $display("  actual   en=%0b flt=%0b cnt=%0d drop=%0b vld=%0b code=%0d sev=%0d t=%0d",
               got.gate_en, got.faulted, got.count, got.dropped, got.valid,
               got.code, got.sev, got.time_left);
    end
  endfunction

  // Result monitor: every strobed status transaction is matched against the
  // oldest prediction. The receiver cannot stall, so nothing is held off here.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst && done) begin
      got.gate_en   = gate_enable;
      got.faulted   = system_faulted;
      got.count     = fault_count;
      got.dropped   = report_dropped;
      got.valid     = entry_valid;
      got.code      = entry_code;
      got.sev       = entry_severity;
      got.time_left = entry_time_left;
      statuses_seen++;
      if (got.dropped) begin
        drops_seen++;
      end
      if (pending_status.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("Unexpected status transaction at cycle %0d", cycle_count);
        end
      end else begin
        want = pending_status.pop_front();
        if (!same_status(want, got)) begin
          note_mismatch("predicted", want, got);
        end
      end
    end
  end

  // Present one command and hold it until the block takes it. Predictions are
  // pushed at the accepting edge, before the result can possibly be strobed.
  // Start stays high after the accepting edge; the block is busy then, and the
  // next command or an idle cycle takes it over.
  task automatic send_command(command_t c);
    while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start           <= 1'b1;
    action          <= c.act;
    elapsed_ms      <= c.elapsed;
    gate_fault_line <= c.fline;
    gate_ready_line <= c.rline;
    speed           <= c.spd;
    fault_code      <= c.code;
    severity        <= c.sev;
    timeout_ms      <= c.tmo;
    read_index      <= c.ridx;
    do begin
      @(posedge clk);
    end while (busy);
    pending_status.push_back(predict_status(c));
    case (c.act)
      ACT_TICK:   ticks_sent++;
      ACT_REPORT: reports_sent++;
      ACT_ACK:    acks_sent++;
      default:    reads_sent++;
    endcase
  endtask

  // Block until every predicted status is back, then let any trailing work
  // settle before the configuration is touched.
  task automatic drain();
    start <= 1'b0;
    while (pending_status.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SPEED_THR:   thr_reg = value[THR_W-1:0];
      REG_GATE_CODE:   gate_code_reg = value[CODE_W-1:0];
      REG_NREADY_CODE: nready_code_reg = value[CODE_W-1:0];
      default:         nready_tmo_reg = value;
    endcase
  endtask

  function automatic command_t make_cmd(logic [ACT_W-1:0] act);
    command_t c;
    c.act     = act;
    c.elapsed = TIME_W'($urandom_range(65535, 0));
    c.fline   = 1'($urandom_range(1, 0));
    c.rline   = 1'($urandom_range(1, 0));
    c.spd     = SPEED_W'($urandom_range(65535, 0));
    c.code    = CODE_W'($urandom_range(255, 0));
    c.sev     = SEV_W'($urandom_range(3, 0));
    c.tmo     = TIME_W'($urandom_range(65535, 0));
    c.ridx    = RIDX_W'($urandom_range(15, 0));
    return c;
  endfunction

  // Random command shaped to keep the table busy: fault codes come mostly from
  // a small pool so duplicates are common, elapsed times are mostly short so
  // timers live a while, and speed sits near the threshold half the time.
  function automatic command_t random_cmd();
    command_t c;
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 35) begin
      c = make_cmd(ACT_TICK);
    end else if (pick < 75) begin
      c = make_cmd(ACT_REPORT);
    end else if (pick < 83) begin
      c = make_cmd(ACT_ACK);
    end else begin
      c = make_cmd(ACT_READ);
    end
    if ($urandom_range(3, 0) != 0) begin
      c.code = CODE_W'($urandom_range(23, 0));
    end
    if ($urandom_range(3, 0) != 0) begin
      c.elapsed = TIME_W'($urandom_range(300, 0));
      c.tmo     = TIME_W'($urandom_range(2000, 0));
    end
    if ($urandom_range(1, 0) != 0) begin
      c.spd = SPEED_W'(int'($urandom_range(80, 0)) - 40);
    end
    // The gate lines mostly sit at their quiet levels.
    c.fline = ($urandom_range(9, 0) == 0);
    c.rline = ($urandom_range(9, 0) != 0);
    return c;
  endfunction

  function automatic directed_row_t row(command_t c);
    directed_row_t r;
    r.cmd       = c;
    r.has_typed = 1'b0;
    r.typed     = '{default: '0};
    return r;
  endfunction

  function automatic directed_row_t typed_row(command_t c, result_t s);
    directed_row_t r;
    r.cmd       = c;
    r.has_typed = 1'b1;
    r.typed     = s;
    return r;
  endfunction

  function automatic command_t cmd(logic [ACT_W-1:0] act, logic [TIME_W-1:0] elapsed,
                                   logic fline, logic rline, logic [SPEED_W-1:0] spd,
                                   logic [CODE_W-1:0] code, logic [SEV_W-1:0] sev,
                                   logic [TIME_W-1:0] tmo, logic [RIDX_W-1:0] ridx);
    command_t c;
    c.act = act; c.elapsed = elapsed; c.fline = fline; c.rline = rline;
    c.spd = spd; c.code = code; c.sev = sev; c.tmo = tmo; c.ridx = ridx;
    return c;
  endfunction

  function automatic result_t st(logic en, logic flt, int cnt, logic drop, logic vld,
                                 logic [CODE_W-1:0] code, logic [SEV_W-1:0] sev,
                                 logic [TIME_W-1:0] t);
    result_t s;
    s.gate_en = en; s.faulted = flt; s.count = CNT_W'(cnt); s.dropped = drop;
    s.valid = vld; s.code = code; s.sev = sev; s.time_left = t;
    return s;
  endfunction

  initial begin
    directed_row_t dir_rows[$];
    result_t       typed;
    command_t      c;

    rst             = 1'b1;
    start           = 1'b0;
    action          = ACT_TICK;
    elapsed_ms      = '0;
    gate_fault_line = 1'b0;
    gate_ready_line = 1'b1;
    speed           = '0;
    fault_code      = '0;
    severity        = SEV_WARNING;
    timeout_ms      = '0;
    read_index      = '0;
    cfg_we          = 1'b0;
    cfg_addr        = REG_SPEED_THR;
    cfg_wdata       = '0;
    mismatches      = 0;
    statuses_seen   = 0;
    send_idle_pct   = 0;
    ticks_sent = 0; reports_sent = 0; acks_sent = 0; reads_sent = 0; drops_seen = 0;
    shadow_reset();

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table. Rows with a typed status pin down values that follow
    // straight from the behavior: the reset state, empty reads, full-table
    // drops and acknowledge of latched entries.
    dir_rows.push_back(typed_row(cmd(ACT_READ, 0, 0, 1, 0, 0, 0, 0, 0),
                                 st(0, 0, 0, 0, 0, 0, 0, 0)));
    dir_rows.push_back(typed_row(cmd(ACT_REPORT, 0, 0, 1, 0, 8'd0, SEV_WARNING, 16'hFFFF, 0),
                                 st(0, 0, 1, 0, 0, 0, 0, 0)));
    dir_rows.push_back(typed_row(cmd(ACT_TICK, 0, 0, 1, 16'h7FFF, 0, 0, 0, 0),
                                 st(1, 0, 1, 0, 0, 0, 0, 0)));
    dir_rows.push_back(typed_row(cmd(ACT_READ, 0, 0, 1, 0, 0, 0, 0, 0),
                                 st(1, 0, 1, 0, 1, 8'd0, SEV_WARNING, 16'hFFFF)));
    // Severity three is stored as latched.
    dir_rows.push_back(row(cmd(ACT_REPORT, 0, 0, 1, 0, 8'd255, SEV_OVER, 16'h1234, 0)));
    dir_rows.push_back(row(cmd(ACT_REPORT, 0, 0, 1, 0, 8'd7, SEV_SELF_CLR, 16'd500, 0)));
    // A self-clearing repeat of a latched code re-arms the timer only.
    dir_rows.push_back(row(cmd(ACT_REPORT, 0, 0, 1, 0, 8'd255, SEV_SELF_CLR, 16'd9, 0)));
    dir_rows.push_back(row(cmd(ACT_READ, 0, 0, 1, 0, 0, 0, 0, 4'd1)));
    // Countdown at full speed saturates but does not clear; then the most
    // negative speed, whose magnitude is 32768, still blocks clearing.
    dir_rows.push_back(row(cmd(ACT_TICK, 16'hFFFF, 0, 1, 16'h7FFF, 0, 0, 0, 0)));
    dir_rows.push_back(row(cmd(ACT_TICK, 16'd0, 0, 1, 16'h8000, 0, 0, 0, 0)));
    dir_rows.push_back(row(cmd(ACT_READ, 0, 0, 1, 0, 0, 0, 0, 4'd2)));
    // Gate fault rising edge, then not-ready falling edge, both on later ticks.
    dir_rows.push_back(row(cmd(ACT_TICK, 16'd1, 1, 1, 16'hFFE0, 0, 0, 0, 0)));
    dir_rows.push_back(row(cmd(ACT_TICK, 16'd1, 1, 0, 16'h7FFF, 0, 0, 0, 0)));
    dir_rows.push_back(row(cmd(ACT_READ, 0, 0, 1, 0, 0, 0, 0, 4'd15)));
    // Slow machine: expired self-clearing entries leave the table. The latched
    // entries still hold the gate off until the next tick.
    dir_rows.push_back(row(cmd(ACT_TICK, 16'd2000, 0, 1, 16'd0, 0, 0, 0, 0)));
    dir_rows.push_back(row(cmd(ACT_ACK, 0, 0, 1, 0, 0, 0, 0, 0)));
    dir_rows.push_back(typed_row(cmd(ACT_READ, 0, 0, 1, 0, 0, 0, 0, 4'd0),
                                 st(0, 0, 1, 0, 1, 8'd0, SEV_WARNING, 16'hFFFF)));
    foreach (dir_rows[i]) begin
      send_command(dir_rows[i].cmd);
      if (dir_rows[i].has_typed) begin
        typed = pending_status[$];
        if (!same_status(typed, dir_rows[i].typed)) begin
          note_mismatch("hand-typed", dir_rows[i].typed, typed);
        end
      end
    end

    // Fill the table with warnings, then overflow it with a new report and a
    // gate fault edge. The full-table drops are typed in.
    for (int i = 1; i < NUM_SLOTS; i++) begin
      send_command(cmd(ACT_REPORT, 0, 0, 1, 0, 8'(100 + i), SEV_WARNING, 0, 0));
    end
    send_command(cmd(ACT_REPORT, 0, 0, 1, 0, 8'd200, SEV_LATCHED, 0, 0));
    typed = pending_status[$];
    if (!same_status(typed, st(0, 0, NUM_SLOTS, 1, 0, 0, 0, 0))) begin
      note_mismatch("hand-typed", st(0, 0, NUM_SLOTS, 1, 0, 0, 0, 0), typed);
    end
    send_command(cmd(ACT_TICK, 16'd0, 0, 1, 0, 0, 0, 0, 0));
    send_command(cmd(ACT_TICK, 16'd0, 1, 1, 0, 0, 0, 0, 0));
    typed = pending_status[$];
    if (!same_status(typed, st(1, 0, NUM_SLOTS, 1, 0, 0, 0, 0))) begin
      note_mismatch("hand-typed", st(1, 0, NUM_SLOTS, 1, 0, 0, 0, 0), typed);
    end
    send_command(cmd(ACT_READ, 0, 0, 1, 0, 0, 0, 0, 4'd15));

    // Random phases, each under its own configuration and one of three sender
    // pacings. The first and last settings sit at the register extremes.
    // Acknowledges and expiring timers keep the table from staying full.
    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          write_reg(REG_SPEED_THR, 16'h7FFF);
          write_reg(REG_GATE_CODE, 16'd0);
          write_reg(REG_NREADY_CODE, 16'd0);
          write_reg(REG_NREADY_TMO, 16'd0);
        end
        5: begin
          write_reg(REG_SPEED_THR, 16'd0);
          write_reg(REG_GATE_CODE, 16'd255);
          write_reg(REG_NREADY_CODE, 16'd254);
          write_reg(REG_NREADY_TMO, 16'hFFFF);
        end
        default: begin
          write_reg(REG_SPEED_THR, CFG_DW'($urandom_range(60, 0)));
          write_reg(REG_GATE_CODE, CFG_DW'($urandom_range(25, 0)));
          write_reg(REG_NREADY_CODE, CFG_DW'($urandom_range(25, 0)));
          write_reg(REG_NREADY_TMO, CFG_DW'($urandom_range(1500, 0)));
        end
      endcase
      case (phase % 3)
        0: send_idle_pct = 0;
        1: send_idle_pct = 87;
        default: send_idle_pct = 15;
      endcase
      for (int n = 0; n < RAND_ITEMS / 6; n++) begin
        c = random_cmd();
        // Now and then shake every field across its whole range.
        if ($urandom_range(15, 0) == 0) begin
          c = make_cmd(c.act);
        end
        send_command(c);
      end
    end

    drain();
    $display("Covered %0d ticks, %0d reports, %0d acknowledges, %0d reads;",
             ticks_sent, reports_sent, acks_sent, reads_sent);
    $display("%0d status transactions checked, %0d flagged drops, %0d mismatches.",
             statuses_seen, drops_seen, mismatches);
    if (mismatches == 0 && pending_status.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
